FILE: design/ssc_pkg.sv
// Shared types and constants for the song sequencer crossfade switch.
// Holds the request, response and job structs and the register index codes.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   // Sizes of the sequencer.
   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 16;

   localparam logic [4:0]  MAX_ORDER    = 5'd16;
   localparam logic [6:0]  MAX_LENGTH   = 7'd64;
   localparam logic [16:0] FULL_FADE    = 17'h10000;

   // Reset values of the configuration registers.
   localparam logic [47:0] LENGTH_RESET = 48'd13403570319555;
   localparam logic [47:0] ORDER_RESET  = 48'd16434824;
   localparam logic [4:0]  COUNT_RESET  = 5'd8;
   localparam logic [4:0]  FCLK_RESET   = 5'd0;
   localparam logic [16:0] RATE_RESET   = 17'd14;
   localparam logic [15:0] PTICK_RESET  = 16'd48;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_LENGTH_TABLE = 3'd0,
      CSR_ORDER_TABLE  = 3'd1,
      CSR_ORDER_COUNT  = 3'd2,
      CSR_FADE_CLOCKS  = 3'd3,
      CSR_FADE_RATE    = 3'd4,
      CSR_PULSE_TICKS  = 3'd5
   } ssc_csr_type;

   typedef logic signed [SAMPLE_BITS-1:0] ssc_sample_type;

   // One request: gates, learn buttons and eight samples.
   typedef struct packed {
      logic                          clock_gate;
      logic                          reset_gate;
      logic [NUM_CHANNELS-1:0]       learn_buttons;
      ssc_sample_type                sample_0;
      ssc_sample_type                sample_1;
      ssc_sample_type                sample_2;
      ssc_sample_type                sample_3;
      ssc_sample_type                sample_4;
      ssc_sample_type                sample_5;
      ssc_sample_type                sample_6;
      ssc_sample_type                sample_7;
   } ssc_req_type;

   // One response.
   typedef struct packed {
      ssc_sample_type                out_sample;
      logic [NUM_CHANNELS-1:0]       pulse_bits;
      logic [2:0]                    active_now;
      logic [NUM_CHANNELS-1:0]       learning_flags;
      logic                          fade_active;
   } ssc_rsp_type;

   // Work handed from the sequencing front end to the mixer.
   typedef struct packed {
      ssc_sample_type                s_old;
      ssc_sample_type                s_new;
      logic [16:0]                   progress;
      logic [NUM_CHANNELS-1:0]       pulses;
      logic [2:0]                    active;
      logic [NUM_CHANNELS-1:0]       lflags;
      logic                          fade;
   } ssc_job_type;

endpackage

`default_nettype wire

FILE: design/song_sequencer_crossfade_switch_top.sv
// Top level of the song sequencer crossfade switch.
// Instantiates ssc_front, ssc_queue and ssc_mix; depends on ssc_pkg.
//
//   Channel   Ports                               Direction  Content
//   request   req_valid / req_ready / req_payload in         gates, buttons, samples
//   response  rsp_valid / rsp_ready / rsp_payload out        mixed sample and status
//   config    csr_we / csr_index / csr_wdata      in         register writes
//
// One request is taken every cycle while the queue has room; the front end updates
// the sequencer state in the cycle it accepts a request. The response passes
// through the queue, the product stage and the response register. Reset is
// synchronous and needs no clearing pass.
// A stalled response side fills the two-entry queue, then drops req_ready.
`timescale 1ns / 1ps
`default_nettype none

module song_sequencer_crossfade_switch_top
   import ssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ssc_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ssc_rsp_type      rsp_payload
);

   logic        fq_valid, fq_ready;
   ssc_job_type fq_job;
   logic        qm_valid, qm_ready;
   ssc_job_type qm_job;

   // Sequencing front end.
   ssc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job         (fq_job)
   );

   // Job queue.
   ssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qm_valid),
      .out_ready (qm_ready),
      .out_job   (qm_job)
   );

   // Crossfade mixer.
   ssc_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qm_valid),
      .job_ready   (qm_ready),
      .job         (qm_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: design/ssc_front.sv
// Sequencing front end: configuration registers, gate edges, learn lanes,
// segment counting, fade control and trigger pulses. Builds one mix job per request.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_front
   import ssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ssc_req_type req_payload,
   output logic             job_valid,
   input  wire logic        job_ready,
   output ssc_job_type      job
);

   // Configuration registers.
   logic [47:0] order_ff;
   logic [4:0]  count_ff;
   logic [4:0]  fclk_ff;
   logic [16:0] rate_ff;
   logic [15:0] pticks_ff;

   // Sequencer state.
   logic [3:0]  pos_ff, pos_in;
   logic [6:0]  cc_ff, cc_in;
   logic [2:0]  act_ff, act_in;
   logic [2:0]  prior_ff, prior_in;
   logic        fade_ff, fade_in;
   logic [16:0] prog_ff, prog_in;
   logic [9:0]  hist_ff, hist_in;
   logic [6:0]  wl_ff  [NUM_CHANNELS];
   logic [6:0]  wl_in  [NUM_CHANNELS];
   logic [6:0]  lc_ff  [NUM_CHANNELS];
   logic [6:0]  lc_in  [NUM_CHANNELS];
   logic [15:0] rem_ff [NUM_CHANNELS];
   logic [15:0] rem_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] lf_ff, lf_in;

   logic        accept;
   logic        rst_edge, clk_edge;
   logic [NUM_CHANNELS-1:0] btn_edge;
   logic [3:0]  pos1;
   logic [6:0]  cc1;
   logic [2:0]  act1;
   logic [4:0]  eff;
   logic [6:0]  len;
   logic signed [7:0] st;
   logic [4:0]  np;
   logic [2:0]  ni;
   logic        load_pulse;
   logic        fade1;
   logic [16:0] prog1;
   logic [17:0] psum;
   logic [NUM_CHANNELS-1:0] pulses;

   // Input index of one play order entry.
   function automatic logic [2:0] order_entry(input logic [47:0] tbl, input logic [3:0] p);
      order_entry = tbl[p*3 +: 3];
   endfunction

   // Sample of one input of the request.
   function automatic ssc_sample_type pick(input ssc_req_type r, input logic [2:0] idx);
      case (idx)
         3'd0: pick = r.sample_0;
         3'd1: pick = r.sample_1;
         3'd2: pick = r.sample_2;
         3'd3: pick = r.sample_3;
         3'd4: pick = r.sample_4;
         3'd5: pick = r.sample_5;
         3'd6: pick = r.sample_6;
         3'd7: pick = r.sample_7;
         default: pick = r.sample_0;
      endcase
   endfunction

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid & job_ready;

   // Gate edges, restart and learn lanes.
   always_comb begin
      rst_edge = req_payload.reset_gate & ~hist_ff[1];
      clk_edge = req_payload.clock_gate & ~hist_ff[0];
      btn_edge = req_payload.learn_buttons & ~hist_ff[9:2];
      hist_in  = {req_payload.learn_buttons, req_payload.reset_gate, req_payload.clock_gate};
      pos1 = rst_edge ? 4'd0 : pos_ff;
      cc1  = rst_edge ? 7'd0 : cc_ff;
      act1 = rst_edge ? order_entry(order_ff, 4'd0) : act_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         lf_in[i] = rst_edge ? 1'b0 : lf_ff[i];
         lc_in[i] = rst_edge ? 7'd0 : lc_ff[i];
         wl_in[i] = wl_ff[i];
         if (btn_edge[i]) begin
            if (lf_in[i]) begin
               if (lc_in[i] != 7'd0) begin
                  wl_in[i] = (lc_in[i] > MAX_LENGTH) ? MAX_LENGTH : lc_in[i];
               end
               lf_in[i] = 1'b0;
            end else begin
               lf_in[i] = 1'b1;
               lc_in[i] = 7'd0;
            end
         end
         if (clk_edge && lf_in[i] && lc_in[i] < MAX_LENGTH) begin
            lc_in[i] = lc_in[i] + 7'd1;
         end
      end
   end

   // Segment counting, order stepping and fade start.
   always_comb begin
      eff = (count_ff == 5'd0) ? 5'd1 : ((count_ff > MAX_ORDER) ? MAX_ORDER : count_ff);
      len = wl_in[act1];
      st  = $signed({1'b0, len}) - $signed({3'b000, fclk_ff});
      cc_in      = cc1;
      pos_in     = pos1;
      act_in     = act1;
      prior_in   = prior_ff;
      fade1      = fade_ff;
      prog1      = prog_ff;
      load_pulse = 1'b0;
      np         = {1'b0, pos1} + 5'd1;
      if (np >= eff) begin
         np = 5'd0;
      end
      ni = order_entry(order_ff, np[3:0]);
      if (clk_edge) begin
         cc_in = cc1 + 7'd1;
         // Early fade: the last fade_clocks clocks of the segment.
         if (fclk_ff != 5'd0 && rate_ff != 17'd0 && !fade_ff) begin
            if ($signed({1'b0, cc_in}) >= st && cc_in < len && ni != act1) begin
               fade1    = 1'b1;
               prior_in = act1;
               prog1    = 17'd0;
            end
         end
         // Segment end: step to the next order entry.
         if (cc_in >= len) begin
            cc_in  = 7'd0;
            pos_in = np[3:0];
            if (!fade1 && ni != act1 && rate_ff != 17'd0) begin
               fade1    = 1'b1;
               prior_in = act1;
               prog1    = 17'd0;
            end
            act_in     = ni;
            load_pulse = 1'b1;
         end
      end
   end

   // Fade progress and trigger pulses.
   always_comb begin
      psum = {1'b0, prog1} + {1'b0, rate_ff};
      if (fade1 && rate_ff != 17'd0 && psum < {1'b0, FULL_FADE}) begin
         fade_in = 1'b1;
         prog_in = psum[16:0];
      end else begin
         fade_in = 1'b0;
         prog_in = FULL_FADE;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         rem_in[i] = rem_ff[i];
         if (load_pulse && ni == 3'(i) && pticks_ff > rem_in[i]) begin
            rem_in[i] = pticks_ff;
         end
         pulses[i] = (rem_in[i] != 16'd0);
         if (pulses[i]) begin
            rem_in[i] = rem_in[i] - 16'd1;
         end
      end
   end

   // Mix job for the back end.
   always_comb begin
      job.s_new    = pick(req_payload, act_in);
      job.s_old    = pick(req_payload, prior_in);
      job.progress = prog_in;
      job.pulses   = pulses;
      job.active   = act_in;
      job.lflags   = lf_in;
      job.fade     = fade_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= ORDER_RESET;
         count_ff  <= COUNT_RESET;
         fclk_ff   <= FCLK_RESET;
         rate_ff   <= RATE_RESET;
         pticks_ff <= PTICK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORDER_TABLE: order_ff  <= csr_wdata;
            CSR_ORDER_COUNT: count_ff  <= csr_wdata[4:0];
            CSR_FADE_CLOCKS: fclk_ff   <= csr_wdata[4:0];
            CSR_FADE_RATE:   rate_ff   <= csr_wdata[16:0];
            CSR_PULSE_TICKS: pticks_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer state, advanced once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         cc_ff    <= 7'd0;
         act_ff   <= 3'd0;
         prior_ff <= 3'd0;
         fade_ff  <= 1'b0;
         prog_ff  <= FULL_FADE;
         hist_ff  <= 10'd0;
         lf_ff    <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            wl_ff[i]  <= {1'b0, LENGTH_RESET[i*6 +: 6]} + 7'd1;
            lc_ff[i]  <= 7'd0;
            rem_ff[i] <= 16'd0;
         end
      end else begin
         if (accept) begin
            pos_ff   <= pos_in;
            cc_ff    <= cc_in;
            act_ff   <= act_in;
            prior_ff <= prior_in;
            fade_ff  <= fade_in;
            prog_ff  <= prog_in;
            hist_ff  <= hist_in;
            lf_ff    <= lf_in;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               lc_ff[i]  <= lc_in[i];
               rem_ff[i] <= rem_in[i];
            end
         end
         // A length table write reloads every working length.
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (csr_we && csr_index == CSR_LENGTH_TABLE) begin
               wl_ff[i] <= {1'b0, csr_wdata[i*6 +: 6]} + 7'd1;
            end else if (accept) begin
               wl_ff[i] <= wl_in[i];
            end
         end
      end
   end

   // Outside a fade the new input is at full weight.
   a_idle_progress: assert property (@(posedge clock) disable iff (reset)
      !fade_ff |-> prog_ff == FULL_FADE)
      else $error("fade progress not full while no fade runs");

   // A restart without a clock edge leaves the order at its first entry.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && rst_edge && !clk_edge) |=> (pos_ff == 4'd0 && cc_ff == 7'd0))
      else $error("restart did not clear position and count");

endmodule

`default_nettype wire

FILE: design/ssc_queue.sv
// Two-entry job queue between the sequencing front end and the mixer.
// Depends on ssc_pkg for the job struct.
`timescale 1ns / 1ps
`default_nettype none

module ssc_queue
   import ssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire ssc_job_type in_job,
   output logic             out_valid,
   input  wire logic        out_ready,
   output ssc_job_type      out_job
);

   ssc_job_type slot_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = slot_ff[rd_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_job;
      end
   end

   // Pointers stay consistent with the fill count.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: design/ssc_mix.sv
// Crossfade mixer: two weighted products, then round, saturate and hold the response.
// Depends on ssc_pkg for the job and response structs.
`timescale 1ns / 1ps
`default_nettype none

module ssc_mix
   import ssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire ssc_job_type job,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ssc_rsp_type      rsp_payload
);

   // Product stage.
   logic                    a_valid_ff;
   logic signed [33:0]      a_pold_ff, a_pnew_ff;
   ssc_sample_type          a_snew_ff;
   logic [NUM_CHANNELS-1:0] a_pulses_ff, a_lflags_ff;
   logic [2:0]              a_active_ff;
   logic                    a_fade_ff;

   // Response register.
   logic                    o_valid_ff;
   ssc_rsp_type             o_rsp_ff, o_rsp_in;

   logic               o_load, a_adv, a_load;
   logic [16:0]        w_old;
   logic signed [34:0] sum;
   logic signed [18:0] q;

   assign o_load    = ~o_valid_ff | rsp_ready;
   assign a_adv     = a_valid_ff & o_load;
   assign a_load    = ~a_valid_ff | o_load;
   assign job_ready = a_load;
   assign w_old     = FULL_FADE - job.progress;

   assign rsp_valid   = o_valid_ff;
   assign rsp_payload = o_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_valid_ff <= job_valid;
         end
         if (o_load) begin
            o_valid_ff <= a_valid_ff;
         end
      end
   end

   // Weighted products of the old and new samples.
   always_ff @(posedge clock) begin
      if (a_load && job_valid) begin
         a_pold_ff   <= job.s_old * $signed({1'b0, w_old});
         a_pnew_ff   <= job.s_new * $signed({1'b0, job.progress});
         a_snew_ff   <= job.s_new;
         a_pulses_ff <= job.pulses;
         a_lflags_ff <= job.lflags;
         a_active_ff <= job.active;
         a_fade_ff   <= job.fade;
      end
   end

   // Sum, round half up, saturate.
   always_comb begin
      sum = {a_pold_ff[33], a_pold_ff} + {a_pnew_ff[33], a_pnew_ff} + 35'sd32768;
      q   = sum[34:16];
      if (q > 19'sd32767) begin
         o_rsp_in.out_sample = 16'sh7FFF;
      end else if (q < -19'sd32768) begin
         o_rsp_in.out_sample = 16'sh8000;
      end else begin
         o_rsp_in.out_sample = q[15:0];
      end
      o_rsp_in.pulse_bits     = a_pulses_ff;
      o_rsp_in.active_now     = a_active_ff;
      o_rsp_in.learning_flags = a_lflags_ff;
      o_rsp_in.fade_active    = a_fade_ff;
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         o_rsp_ff <= o_rsp_in;
      end
   end

   // Without a fade the new sample passes through unchanged.
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (a_adv && !a_fade_ff) |=> rsp_payload.out_sample == $past(a_snew_ff))
      else $error("unfaded sample altered by mixer");

   // A waiting response holds while the consumer stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
